FILE: rtl/hpr_pkg.sv
// Shared types and constants of the hazard pointer reclaimer.
package hpr_pkg;

   localparam int NUM_RECORDS      = 16;
   localparam int SLOTS_PER_RECORD = 4;
   localparam int RETIRED_DEPTH    = 32;
   localparam int ADDR_BITS        = 48;
   localparam int NUM_CTX          = 16;

   localparam int REC_W = $clog2(NUM_RECORDS);
   localparam int CTX_W = $clog2(NUM_CTX);
   localparam int IDX_W = $clog2(RETIRED_DEPTH);
   localparam int CNT_W = 6;
   localparam int TAG_W = 8;
   localparam int RADDR_W = CTX_W + IDX_W;

   typedef enum logic [2:0] {
      CMD_ACQUIRE = 3'd0,
      CMD_PROTECT = 3'd1,
      CMD_CLEAR   = 3'd2,
      CMD_RETIRE  = 3'd3,
      CMD_EXIT    = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_RECORD = 2'd1,
      ST_LIST_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]           cmd;
      logic [CTX_W-1:0]     thread_ctx;
      logic [1:0]           slot;
      logic [ADDR_BITS-1:0] ptr_in;
      logic [TAG_W-1:0]     deleter_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [REC_W-1:0]     record_index;
      logic                 is_freed;
      logic [ADDR_BITS-1:0] ptr_out;
      logic [TAG_W-1:0]     tag_out;
      logic [CNT_W-1:0]     retired_left;
      logic                 last;
   } rsp_type;

   typedef logic [SLOTS_PER_RECORD-1:0][ADDR_BITS-1:0] slot_row_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] ptr;
      logic [TAG_W-1:0]     tag;
   } entry_type;

   typedef struct packed {
      logic [REC_W-1:0] rd_addr;
      logic             wr_en;
      logic [REC_W-1:0] wr_addr;
      slot_row_type     wr_row;
      logic             clr_en;
      logic [REC_W-1:0] clr_addr;
   } slot_req_type;

   typedef struct packed {
      logic              wr_en;
      logic [RADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic [RADDR_W-1:0] rd_addr;
   } ret_req_type;

endpackage

FILE: rtl/hpr_slot_ram.sv
// Hazard slot rows, one row per record, with per-row valid bits for reset.
module hpr_slot_ram (
   input  logic                  clock,
   input  logic                  reset,
   input  hpr_pkg::slot_req_type req,
   output hpr_pkg::slot_row_type rd_row
);

   hpr_pkg::slot_row_type                 mem [hpr_pkg::NUM_RECORDS];
   logic [hpr_pkg::NUM_RECORDS-1:0]       valid_ff;
   logic [hpr_pkg::NUM_RECORDS-1:0]       valid_in;
   hpr_pkg::slot_row_type                 row_ff;
   logic                                  rv_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req.wr_en) begin
         valid_in[req.wr_addr] = 1'b1;
      end
      if (req.clr_en) begin
         valid_in[req.clr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_row;
      end
      row_ff <= mem[req.rd_addr];
      rv_ff  <= valid_ff[req.rd_addr];
   end

   // invalid row reads as all null
   assign rd_row = rv_ff ? row_ff : '0;

endmodule

FILE: rtl/hpr_retired_ram.sv
// Retired list storage: one list of entries per thread context.
module hpr_retired_ram (
   input  logic                 clock,
   input  hpr_pkg::ret_req_type req,
   output hpr_pkg::entry_type   rd_data
);

   hpr_pkg::entry_type mem [2**hpr_pkg::RADDR_W];
   hpr_pkg::entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rd_ff <= mem[req.rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

FILE: rtl/hazard_pointer_reclaimer.sv
// Top level of the hazard pointer reclaimer: command sequencer and state.
//
// Usage:
//  - Commands enter on req_data when start is high and busy is low; one
//    command is handled at a time. busy drops as the final result shows.
//  - Results leave on rsp_data, one per cycle where rsp_valid strobes high;
//    the receiver cannot stall, so each result shows for one cycle only.
//    A command gives one result per freed pointer, then a final result
//    with last set.
//  - Acquire, retire without scan, clear of an unbound context, exit of an
//    empty list and unused codes go from accept to the final state; protect
//    and clear of a bound context first read and rewrite the slot row.
//  - A scan of n entries walks the list twice through the retired memory:
//    pass one compares each entry against the hazard rows, one record row
//    per cycle through the single read port of the slot row memory; pass
//    two rereads each entry to free or compact it.
//  - Threshold register at csr byte address 0, written through the APB
//    style port at any time the block is idle.
//  - Reset (synchronous) clears records, bindings, slot rows (valid bits)
//    and list counts; no clearing pass is needed and start is taken at once.
module hazard_pointer_reclaimer (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hpr_pkg::req_type req_data,
   output logic             rsp_valid,
   output hpr_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_PROT_RD = 9'b000000010,
      S_PROT_WR = 9'b000000100,
      S_SC_RD   = 9'b000001000,
      S_SC_LD   = 9'b000010000,
      S_SC_CMP  = 9'b000100000,
      S_EM_RD   = 9'b001000000,
      S_EM_DO   = 9'b010000000,
      S_FINAL   = 9'b100000000
   } state_type;

   localparam int REC_W = hpr_pkg::REC_W;
   localparam int CNT_W = hpr_pkg::CNT_W;
   localparam int IDX_W = hpr_pkg::IDX_W;
   localparam int NR    = hpr_pkg::NUM_RECORDS;
   localparam int NC    = hpr_pkg::NUM_CTX;
   localparam int NS    = hpr_pkg::SLOTS_PER_RECORD;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(hpr_pkg::RETIRED_DEPTH);

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          thr_ff, thr_in;
   logic [NR-1:0]             active_ff, active_in;
   logic [NC-1:0]             bound_ff, bound_in;
   logic [REC_W-1:0]          brec_ff [NC];
   logic [REC_W-1:0]          brec_in [NC];
   logic [CNT_W-1:0]          cnt_ff [NC];
   logic [CNT_W-1:0]          cnt_in [NC];

   hpr_pkg::req_type          cmd_ff, cmd_in;
   logic [1:0]                status_ff, status_in;
   logic [hpr_pkg::ADDR_BITS-1:0] pout_ff, pout_in;
   logic [REC_W-1:0]          rec_ff, rec_in;       // row being modified
   logic [hpr_pkg::ADDR_BITS-1:0] wval_ff, wval_in; // value for slot write
   logic [CNT_W-1:0]          n_ff, n_in;           // entries to scan
   logic [IDX_W-1:0]          i_ff, i_in;
   logic [REC_W-1:0]          r_ff, r_in;
   logic                      hit_ff, hit_in;
   logic [hpr_pkg::RETIRED_DEPTH-1:0] flags_ff, flags_in;
   logic [CNT_W-1:0]          keep_ff, keep_in;
   logic [IDX_W-1:0]          wk_ff, wk_in;
   logic [hpr_pkg::ADDR_BITS-1:0] cur_ff, cur_in;
   logic                      upd_ff, upd_in;
   logic [CNT_W-1:0]          ncnt_ff, ncnt_in;
   logic                      rv_ff, rv_in;
   hpr_pkg::rsp_type          rsp_ff, rsp_in;

   hpr_pkg::slot_req_type     sreq;
   hpr_pkg::slot_row_type     srow;
   hpr_pkg::ret_req_type      rreq;
   hpr_pkg::entry_type        rdata;

   logic                      accept;
   logic                      free_found;
   logic [REC_W-1:0]          free_rec;
   logic [hpr_pkg::CTX_W-1:0] ctx;
   logic [CNT_W-1:0]          cnt_cur;
   logic [CNT_W-1:0]          cnt_new;
   logic                      row_hit;
   logic                      last_entry;
   logic [REC_W-1:0]          ridx;
   logic                      csr_wr;

   hpr_slot_ram u_slot_ram (
      .clock  (clock),
      .reset  (reset),
      .req    (sreq),
      .rd_row (srow)
   );

   hpr_retired_ram u_retired_ram (
      .clock   (clock),
      .req     (rreq),
      .rd_data (rdata)
   );

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = {{(32-CNT_W){1'b0}}, thr_ff};

   // context of the transaction in flight (or arriving)
   assign ctx     = accept ? req_data.thread_ctx : cmd_ff.thread_ctx;
   assign cnt_cur = cnt_ff[ctx];
   assign cnt_new = cnt_cur + CNT_W'(1);
   assign ridx    = bound_ff[ctx] ? brec_ff[ctx] : '0;

   // first inactive record
   always_comb begin
      free_found = 1'b0;
      free_rec   = '0;
      for (int k = NR - 1; k >= 0; k--) begin
         if (!active_ff[k]) begin
            free_found = 1'b1;
            free_rec   = REC_W'(k);
         end
      end
   end

   // one record row against the entry under test
   always_comb begin
      row_hit = 1'b0;
      for (int k = 0; k < NS; k++) begin
         if (srow[k] == cur_ff) begin
            row_hit = 1'b1;
         end
      end
      row_hit = row_hit && active_ff[r_ff] && (cur_ff != '0);
   end

   assign last_entry = ({1'b0, i_ff} == (n_ff - CNT_W'(1)));

   always_comb begin
      state_in  = state_ff;
      thr_in    = thr_ff;
      active_in = active_ff;
      bound_in  = bound_ff;
      brec_in   = brec_ff;
      cnt_in    = cnt_ff;
      cmd_in    = cmd_ff;
      status_in = status_ff;
      pout_in   = pout_ff;
      rec_in    = rec_ff;
      wval_in   = wval_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      r_in      = r_ff;
      hit_in    = hit_ff;
      flags_in  = flags_ff;
      keep_in   = keep_ff;
      wk_in     = wk_ff;
      cur_in    = cur_ff;
      upd_in    = upd_ff;
      ncnt_in   = ncnt_ff;
      rv_in     = 1'b0;
      rsp_in    = rsp_ff;

      sreq          = '0;
      sreq.rd_addr  = rec_ff;
      sreq.wr_addr  = rec_ff;
      sreq.clr_addr = rec_ff;
      rreq          = '0;
      rreq.rd_addr  = {ctx, i_ff};
      rreq.wr_addr  = {ctx, wk_ff};
      rreq.wr_data  = rdata;

      if (csr_wr && !csr_paddr[2]) begin
         thr_in = csr_pwdata[CNT_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in    = req_data;
               status_in = hpr_pkg::ST_OK;
               pout_in   = '0;
               upd_in    = 1'b0;
               i_in      = '0;
               keep_in   = '0;
               flags_in  = '0;
               state_in  = S_FINAL;
               unique case (req_data.cmd)
                  hpr_pkg::CMD_ACQUIRE, hpr_pkg::CMD_PROTECT: begin
                     if (bound_ff[ctx]) begin
                        rec_in = brec_ff[ctx];
                     end else begin
                        rec_in = free_rec;
                     end
                     if (!bound_ff[ctx] && !free_found) begin
                        status_in = hpr_pkg::ST_NO_RECORD;
                     end else begin
                        if (!bound_ff[ctx]) begin
                           active_in[free_rec] = 1'b1;
                           bound_in[ctx]       = 1'b1;
                           brec_in[ctx]        = free_rec;
                        end
                        if (req_data.cmd == hpr_pkg::CMD_PROTECT) begin
                           pout_in  = req_data.ptr_in;
                           wval_in  = req_data.ptr_in;
                           state_in = S_PROT_RD;
                        end
                     end
                  end
                  hpr_pkg::CMD_CLEAR: begin
                     if (bound_ff[ctx]) begin
                        rec_in   = brec_ff[ctx];
                        wval_in  = '0;
                        state_in = S_PROT_RD;
                     end
                  end
                  hpr_pkg::CMD_RETIRE: begin
                     if (cnt_cur >= DEPTH_C) begin
                        status_in = hpr_pkg::ST_LIST_FULL;
                     end else begin
                        rreq.wr_en        = 1'b1;
                        rreq.wr_addr      = {ctx, cnt_cur[IDX_W-1:0]};
                        rreq.wr_data.ptr  = req_data.ptr_in;
                        rreq.wr_data.tag  = req_data.deleter_tag;
                        cnt_in[ctx]       = cnt_new;
                        if (cnt_new >= thr_ff) begin
                           n_in     = cnt_new;
                           state_in = S_SC_RD;
                        end
                     end
                  end
                  hpr_pkg::CMD_EXIT: begin
                     // own row cleared first; the scan then sees other records
                     if (bound_ff[ctx]) begin
                        sreq.clr_en   = 1'b1;
                        sreq.clr_addr = brec_ff[ctx];
                        active_in[brec_ff[ctx]] = 1'b0;
                     end
                     bound_in[ctx] = 1'b0;
                     brec_in[ctx]  = '0;
                     upd_in        = 1'b1;
                     ncnt_in       = '0;
                     n_in          = cnt_cur;
                     if (cnt_cur != '0) begin
                        state_in = S_SC_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PROT_RD: begin
            sreq.rd_addr = rec_ff;
            state_in     = S_PROT_WR;
         end
         S_PROT_WR: begin
            sreq.wr_en   = 1'b1;
            sreq.wr_row  = srow;
            sreq.wr_row[cmd_ff.slot] = wval_ff;
            state_in     = S_FINAL;
         end
         S_SC_RD: begin
            state_in = S_SC_LD;
         end
         S_SC_LD: begin
            cur_in       = rdata.ptr;
            sreq.rd_addr = '0;
            r_in         = '0;
            hit_in       = 1'b0;
            state_in     = S_SC_CMP;
         end
         S_SC_CMP: begin
            sreq.rd_addr = r_ff + REC_W'(1);
            r_in         = r_ff + REC_W'(1);
            hit_in       = hit_ff || row_hit;
            if (r_ff == REC_W'(NR - 1)) begin
               flags_in[i_ff] = hit_ff || row_hit;
               if (hit_ff || row_hit) begin
                  keep_in = keep_ff + CNT_W'(1);
               end
               if (last_entry) begin
                  i_in    = '0;
                  wk_in   = '0;
                  upd_in  = 1'b1;
                  if (cmd_ff.cmd != hpr_pkg::CMD_EXIT) begin
                     ncnt_in = (hit_ff || row_hit) ? keep_ff + CNT_W'(1) : keep_ff;
                  end
                  state_in = S_EM_RD;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = S_SC_RD;
               end
            end
         end
         S_EM_RD: begin
            state_in = S_EM_DO;
         end
         S_EM_DO: begin
            if (flags_ff[i_ff]) begin
               // survivor moves down to its compacted place
               rreq.wr_en = 1'b1;
               wk_in      = wk_ff + IDX_W'(1);
            end else begin
               rv_in               = 1'b1;
               rsp_in.status       = hpr_pkg::ST_OK;
               rsp_in.record_index = ridx;
               rsp_in.is_freed     = 1'b1;
               rsp_in.ptr_out      = rdata.ptr;
               rsp_in.tag_out      = rdata.tag;
               rsp_in.retired_left = ncnt_ff;
               rsp_in.last         = 1'b0;
            end
            if (last_entry) begin
               state_in = S_FINAL;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = S_EM_RD;
            end
         end
         S_FINAL: begin
            if (upd_ff) begin
               cnt_in[ctx] = ncnt_ff;
            end
            rv_in               = 1'b1;
            rsp_in.status       = status_ff;
            rsp_in.record_index = ridx;
            rsp_in.is_freed     = 1'b0;
            rsp_in.ptr_out      = pout_ff;
            rsp_in.tag_out      = '0;
            rsp_in.retired_left = upd_ff ? ncnt_ff : cnt_cur;
            rsp_in.last         = 1'b1;
            state_in            = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         thr_ff    <= CNT_W'(16);
         active_ff <= '0;
         bound_ff  <= '0;
         rv_ff     <= 1'b0;
         for (int k = 0; k < NC; k++) begin
            brec_ff[k] <= '0;
            cnt_ff[k]  <= '0;
         end
      end else begin
         state_ff  <= state_in;
         thr_ff    <= thr_in;
         active_ff <= active_in;
         bound_ff  <= bound_in;
         rv_ff     <= rv_in;
         brec_ff   <= brec_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      pout_ff   <= pout_in;
      rec_ff    <= rec_in;
      wval_ff   <= wval_in;
      n_ff      <= n_in;
      i_ff      <= i_in;
      r_ff      <= r_in;
      hit_ff    <= hit_in;
      flags_ff  <= flags_in;
      keep_ff   <= keep_in;
      wk_ff     <= wk_in;
      cur_ff    <= cur_in;
      upd_ff    <= upd_in;
      ncnt_ff   <= ncnt_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // the sequencer goes idle only as the final result of a transaction leaves
   a_done_with_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_valid && rsp_data.last))
      else $error("went idle without final result");

   // freed-pointer results come only while a transaction is still running
   a_freed_while_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> busy)
      else $error("freed result outside a transaction");

   a_freed_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_freed) |-> (!rsp_data.last &&
         rsp_data.status == hpr_pkg::ST_OK))
      else $error("freed result marked last or with error");

   a_left_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.retired_left <= DEPTH_C))
      else $error("retired count beyond list depth");
`endif

endmodule

FILE: sim/hazard_pointer_reclaimer_tb.sv
// Testbench for the hazard pointer reclaimer: directed and random commands vs. a predictor.
`timescale 1ns / 100ps

module hazard_pointer_reclaimer_tb;

   localparam int CYCLE_LIMIT = 1000000;
   // Settling time after the last result.
   localparam int SETTLE = 16;
   localparam int AW = hpr_pkg::ADDR_BITS;
   localparam int NREC = hpr_pkg::NUM_RECORDS;
   localparam int NSLOT = hpr_pkg::SLOTS_PER_RECORD;
   localparam int NCTX = hpr_pkg::NUM_CTX;
   localparam int DEPTH = hpr_pkg::RETIRED_DEPTH;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   hpr_pkg::req_type req_data = '0;
   logic             rsp_valid;
   hpr_pkg::rsp_type rsp_data;
   logic             csr_psel = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite = 1'b0;
   logic [2:0]       csr_paddr = '0;
   logic [31:0]      csr_pwdata = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   hazard_pointer_reclaimer DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   // Shadow state of the engine.
   logic [5:0]                  threshold = 6'd16;
   logic                        rec_active [NREC];
   logic [AW-1:0]               hazard [NREC][NSLOT];
   logic                        ctx_bound [NCTX];
   logic [hpr_pkg::REC_W-1:0]   ctx_rec [NCTX];
   hpr_pkg::entry_type          retired [NCTX][DEPTH];
   int                          retired_cnt [NCTX];

   hpr_pkg::req_type            pending_cmds [$];
   hpr_pkg::rsp_type            expected_rsps [$];
   logic [AW-1:0]               ptr_pool [8];

   int   errors = 0;
   int   cycles = 0;
   int   burst_left = 1;
   int   gap_left = 0;
   logic hold = 1'b0;

   task automatic report(string what, logic [63:0] want, logic [63:0] got);
      $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
      errors++;
   endtask

   function automatic logic held(logic [AW-1:0] p);
      if (p == '0) return 1'b0;
      for (int r = 0; r < NREC; r++)
         if (rec_active[r])
            for (int s = 0; s < NSLOT; s++)
               if (hazard[r][s] == p) return 1'b1;
      return 1'b0;
   endfunction

   // Bind the first free record to ctx unless it is bound already.
   function automatic logic bind_record(int ctx);
      if (ctx_bound[ctx]) return 1'b1;
      for (int r = 0; r < NREC; r++)
         if (!rec_active[r]) begin
            rec_active[r] = 1'b1;
            ctx_bound[ctx] = 1'b1;
            ctx_rec[ctx] = hpr_pkg::REC_W'(r);
            return 1'b1;
         end
      return 1'b0;
   endfunction

   // Work out the transactions one command produces and queue them.
   function automatic void predict_reclaim(hpr_pkg::req_type c);
      int                   ctx;
      int                   keep;
      hpr_pkg::entry_type   freed [$];
      hpr_pkg::rsp_type     r;
      logic [1:0]           st;
      logic [AW-1:0]        pout;
      logic                 do_scan;
      ctx = int'(c.thread_ctx);
      st = hpr_pkg::ST_OK;
      pout = '0;
      do_scan = 1'b0;
      case (c.cmd)
         hpr_pkg::CMD_ACQUIRE: begin
            if (!bind_record(ctx)) st = hpr_pkg::ST_NO_RECORD;
         end
         hpr_pkg::CMD_PROTECT: begin
            if (!bind_record(ctx)) st = hpr_pkg::ST_NO_RECORD;
            else begin
               hazard[ctx_rec[ctx]][c.slot] = c.ptr_in;
               pout = c.ptr_in;
            end
         end
         hpr_pkg::CMD_CLEAR: begin
            if (ctx_bound[ctx]) hazard[ctx_rec[ctx]][c.slot] = '0;
         end
         hpr_pkg::CMD_RETIRE: begin
            if (retired_cnt[ctx] >= DEPTH) st = hpr_pkg::ST_LIST_FULL;
            else begin
               retired[ctx][retired_cnt[ctx]] = '{ptr: c.ptr_in, tag: c.deleter_tag};
               retired_cnt[ctx]++;
               do_scan = (retired_cnt[ctx] >= int'(threshold));
            end
         end
         hpr_pkg::CMD_EXIT: begin
            if (ctx_bound[ctx])
               for (int s = 0; s < NSLOT; s++) hazard[ctx_rec[ctx]][s] = '0;
            do_scan = 1'b1;
         end
         default: ;
      endcase
      if (do_scan) begin
         keep = 0;
         for (int i = 0; i < retired_cnt[ctx]; i++)
            if (held(retired[ctx][i].ptr)) begin
               retired[ctx][keep] = retired[ctx][i];
               keep++;
            end else begin
               freed = {freed, retired[ctx][i]};
            end
         retired_cnt[ctx] = keep;
      end
      if (c.cmd == hpr_pkg::CMD_EXIT) begin
         if (ctx_bound[ctx]) rec_active[ctx_rec[ctx]] = 1'b0;
         ctx_bound[ctx] = 1'b0;
         ctx_rec[ctx] = '0;
         retired_cnt[ctx] = 0;
      end
      r = '0;
      r.record_index = ctx_bound[ctx] ? ctx_rec[ctx] : '0;
      r.retired_left = hpr_pkg::CNT_W'(retired_cnt[ctx]);
      foreach (freed[k]) begin
         r.is_freed = 1'b1;
         r.ptr_out = freed[k].ptr;
         r.tag_out = freed[k].tag;
         expected_rsps = {expected_rsps, r};
      end
      r.status = st;
      r.is_freed = 1'b0;
      r.ptr_out = pout;
      r.tag_out = '0;
      r.last = 1'b1;
      expected_rsps = {expected_rsps, r};
   endfunction

   function automatic void add_cmd(hpr_pkg::cmd_type c, int ctx, int slot,
                                   logic [AW-1:0] p, logic [7:0] tag);
      hpr_pkg::req_type q;
      q.cmd = c;
      q.thread_ctx = hpr_pkg::CTX_W'(ctx);
      q.slot = 2'(slot);
      q.ptr_in = p;
      q.deleter_tag = tag;
      pending_cmds = {pending_cmds, q};
   endfunction

   function automatic logic [AW-1:0] pick_ptr();
      if ($urandom_range(0, 9) < 7) return ptr_pool[$urandom_range(0, 7)];
      return AW'({$urandom, $urandom});
   endfunction

   // Driver: a command stays on req_data until start && !busy takes it.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_reclaim(pending_cmds.pop_front());
         end
         if (start && busy) begin
            // transaction still waiting
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (!hold && pending_cmds.size() > 0) begin
            start <= 1'b1;
            req_data <= pending_cmds[0];
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: results cannot be stalled, so every strobe is a transaction.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            report("unexpected result", 64'd0, 64'(rsp_data));
         end else begin
            hpr_pkg::rsp_type w;
            w = expected_rsps.pop_front();
            if (rsp_data.status != w.status)
               report("status", 64'(w.status), 64'(rsp_data.status));
            if (rsp_data.record_index != w.record_index)
               report("record_index", 64'(w.record_index), 64'(rsp_data.record_index));
            if (rsp_data.is_freed != w.is_freed)
               report("is_freed", 64'(w.is_freed), 64'(rsp_data.is_freed));
            if (rsp_data.ptr_out != w.ptr_out)
               report("ptr_out", 64'(w.ptr_out), 64'(rsp_data.ptr_out));
            if (rsp_data.tag_out != w.tag_out)
               report("tag_out", 64'(w.tag_out), 64'(rsp_data.tag_out));
            if (rsp_data.retired_left != w.retired_left)
               report("retired_left", 64'(w.retired_left), 64'(rsp_data.retired_left));
            if (rsp_data.last != w.last)
               report("last", 64'(w.last), 64'(rsp_data.last));
         end
      end
   end

   // Wait until the engine has drained everything queued so far.
   task automatic drain();
      do @(posedge clock);
      while (pending_cmds.size() > 0 || start || busy || expected_rsps.size() > 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Stop sending mid-stream until every expected result has come, then resume.
   task automatic pause_until_empty();
      repeat (40) @(posedge clock);
      hold <= 1'b1;
      do @(posedge clock);
      while (start || busy || expected_rsps.size() > 0);
      hold <= 1'b0;
   endtask

   // APB write of the threshold, then a read back of it.
   task automatic set_threshold(logic [5:0] value);
      csr_paddr <= '0;
      csr_pwdata <= 32'(value);
      csr_pwrite <= 1'b1;
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      threshold = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[5:0] != value) report("threshold read", 64'(value), 64'(csr_prdata[5:0]));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(int count);
      int ctx;
      for (int i = 0; i < count; i++) begin
         // contexts 0..3 get most traffic so lists fill and slots collide
         ctx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
         case ($urandom_range(0, 9))
            0:       add_cmd(hpr_pkg::CMD_ACQUIRE, ctx, 0, pick_ptr(), 8'($urandom));
            1, 2:    add_cmd(hpr_pkg::CMD_PROTECT, ctx, $urandom_range(0, 3), pick_ptr(),
                             8'($urandom));
            3:       add_cmd(hpr_pkg::CMD_CLEAR, ctx, $urandom_range(0, 3), pick_ptr(),
                             8'($urandom));
            4:       add_cmd(hpr_pkg::CMD_EXIT, ctx, $urandom_range(0, 3), pick_ptr(),
                             8'($urandom));
            default: add_cmd(hpr_pkg::CMD_RETIRE, ctx, $urandom_range(0, 3), pick_ptr(),
                             8'($urandom));
         endcase
      end
   endtask

   initial begin
      for (int i = 0; i < NREC; i++) begin
         rec_active[i] = 1'b0;
         for (int s = 0; s < NSLOT; s++) hazard[i][s] = '0;
      end
      for (int i = 0; i < NCTX; i++) begin
         ctx_bound[i] = 1'b0;
         ctx_rec[i] = '0;
         retired_cnt[i] = 0;
      end
      ptr_pool[0] = '0;
      ptr_pool[1] = '1;
      ptr_pool[2] = 48'h1;
      ptr_pool[3] = 48'h8000_0000_0000;
      for (int i = 4; i < 8; i++) ptr_pool[i] = AW'({$urandom, $urandom});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: scan on every retire, protected pointers survive.
      set_threshold(6'd1);
      add_cmd(hpr_pkg::CMD_ACQUIRE, 0, 0, '0, 8'h00);
      add_cmd(hpr_pkg::CMD_ACQUIRE, 0, 0, '0, 8'h00);            // already bound
      add_cmd(hpr_pkg::CMD_PROTECT, 0, 0, ptr_pool[2], 8'h00);
      add_cmd(hpr_pkg::CMD_PROTECT, 1, 3, ptr_pool[1], 8'hFF);   // protect binds a record
      add_cmd(hpr_pkg::CMD_RETIRE, 2, 0, ptr_pool[2], 8'hA5);    // held, survives
      add_cmd(hpr_pkg::CMD_RETIRE, 2, 0, '0, 8'hFF);             // null is always freed
      add_cmd(hpr_pkg::CMD_RETIRE, 2, 1, ptr_pool[3], 8'h5A);
      add_cmd(hpr_pkg::CMD_RETIRE, 2, 2, ptr_pool[1], 8'h01);
      add_cmd(hpr_pkg::CMD_CLEAR, 0, 0, '0, 8'h00);
      add_cmd(hpr_pkg::CMD_CLEAR, 5, 2, '0, 8'h00);              // unbound context
      add_cmd(hpr_pkg::CMD_RETIRE, 2, 3, ptr_pool[4], 8'h77);    // frees the now unheld one
      add_cmd(hpr_pkg::CMD_EXIT, 1, 0, '0, 8'h00);
      add_cmd(hpr_pkg::CMD_RETIRE, 2, 0, ptr_pool[1], 8'h33);
      add_cmd(hpr_pkg::CMD_EXIT, 0, 0, '0, 8'h00);
      add_cmd(hpr_pkg::CMD_EXIT, 3, 0, '0, 8'h00);               // unbound context
      drain();

      // Full list: every entry held, so the scan at depth frees none.
      set_threshold(6'd32);
      add_cmd(hpr_pkg::CMD_PROTECT, 4, 1, ptr_pool[5], 8'h00);
      for (int i = 0; i < DEPTH + 1; i++)
         add_cmd(hpr_pkg::CMD_RETIRE, 5, 0, ptr_pool[5], 8'($urandom));
      add_cmd(hpr_pkg::CMD_EXIT, 5, 0, '0, 8'h00);
      add_cmd(hpr_pkg::CMD_EXIT, 4, 0, '0, 8'h00);
      drain();

      set_threshold(6'($urandom_range(2, 6)));
      random_phase(20);
      random_phase(10);
      pause_until_empty();
      drain();
      set_threshold(6'd32);
      random_phase(25);
      drain();
      set_threshold(6'd1);
      random_phase(25);
      drain();
      set_threshold(6'd16);
      random_phase(25);
      drain();

      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: hazard_pointer_reclaimer.f
rtl/hpr_pkg.sv
rtl/hpr_slot_ram.sv
rtl/hpr_retired_ram.sv
rtl/hazard_pointer_reclaimer.sv
sim/hazard_pointer_reclaimer_tb.sv
